>>> hdl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Token kinds, scan modes, word table and character classes for the scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int WORD_COUNT = 15;
  localparam int TYPE_COUNT = 4;

  typedef enum logic [3:0] {
    KIND_TYPE    = 4'd0,
    KIND_KEYWORD = 4'd1,
    KIND_SYMBOL  = 4'd2,
    KIND_IDENT   = 4'd3,
    KIND_NUMBER  = 4'd4,
    KIND_LINECMT = 4'd5,
    KIND_BLKCMT  = 4'd6,
    KIND_STRING  = 4'd7,
    KIND_BAD     = 4'd8,
    KIND_UNTERM  = 4'd9
  } kind_t;

  typedef enum logic [6:0] {
    M_IDLE   = 7'b0000001,
    M_IDENT  = 7'b0000010,
    M_NUMBER = 7'b0000100,
    M_SLASH  = 7'b0001000,
    M_LINE   = 7'b0010000,
    M_BLOCK  = 7'b0100000,
    M_STRING = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [3:0] idx;
    logic [7:0] ch;
    logic [15:0] s;
    logic [15:0] e;
    logic [15:0] line;
  } tok_t;

  function automatic logic [3:0] word_len(input int j);
    case (j)
      0, 1:        return 4'd7;
      2, 5, 12, 13: return 4'd4;
      3, 11:       return 4'd6;
      4, 6, 10, 14: return 4'd5;
      7:           return 4'd3;
      8:           return 4'd8;
      default:     return 4'd2;
    endcase
  endfunction

  function automatic logic [7:0] word_at(input int j, input logic [3:0] col);
    logic [63:0] w;
    logic [3:0]  len;
    int          sh;
    case (j)
      0:  w = 64'("integer");
      1:  w = 64'("boolean");
      2:  w = 64'("char");
      3:  w = 64'("string");
      4:  w = 64'("array");
      5:  w = 64'("else");
      6:  w = 64'("false");
      7:  w = 64'("for");
      8:  w = 64'("function");
      9:  w = 64'("if");
      10: w = 64'("print");
      11: w = 64'("return");
      12: w = 64'("true");
      13: w = 64'("void");
      default: w = 64'("while");
    endcase
    len = word_len(j);
    if (col >= len) return 8'd0;
    sh = 8 * (int'(len) - 1 - int'(col));
    return 8'(w >> sh);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_symbol(input logic [7:0] c);
    return c == ":" || c == 8'h27 || c == ";" || c == "[" || c == "]" ||
           c == "{" || c == "}" || c == "(" || c == ")" || c == "^" ||
           c == "%" || c == "+" || c == "-" || c == ">" || c == "<" ||
           c == "&" || c == "|" || c == "!" || c == "*" || c == "=";
  endfunction

endpackage

>>> hdl/sts_core.sv
// ----------------------------------------------------------------------------
// sts_core
// Scan state and token decode for one byte per cycle while adv is high; gives up to two tokens.
// ----------------------------------------------------------------------------
module sts_core #(
  parameter int OFFSET_BITS  = 16,
  parameter int MAX_WORD_LEN = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic [7:0]    c,
  input  logic          last,
  output sts_pkg::tok_t tok0,
  output sts_pkg::tok_t tok1
);
  import sts_pkg::*;

  localparam logic [OFFSET_BITS-1:0] CMAX = '1;

  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, lc_r, lc_nxt, ts_r, ts_nxt, tl_r, tl_nxt;
  logic [WORD_COUNT-1:0]  cand_r, cand_nxt;
  logic [3:0]             len_r, len_nxt;
  logic                   star_r, star_nxt;

  function automatic logic [15:0] clip(input logic [OFFSET_BITS-1:0] v);
    logic [OFFSET_BITS+15:0] w;
    w = {16'd0, v};
    return (w > 32'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  always_comb begin
    logic [OFFSET_BITS-1:0] cur, prev;
    logic                   used;
    logic [WORD_COUNT-1:0]  keep;
    logic                   hit;
    tok_t                   t;
    int                     n;
    tok_t                   r [2];
    cur = off_r;
    prev = (cur > ts_r) ? cur - 1'b1 : ts_r;
    used = 1'b0;
    mode_nxt = mode_r; off_nxt = off_r; lc_nxt = lc_r; ts_nxt = ts_r; tl_nxt = tl_r;
    cand_nxt = cand_r; len_nxt = len_r; star_nxt = star_r;
    n = 0;
    r[0] = '0; r[1] = '0;
    t = '0;
    keep = '0;
    hit = 1'b0;

    case (mode_r)
      M_IDENT: begin
        if (is_letter(c) || is_digit(c) || c == "_") begin
          used = 1'b1;
          for (int j = 0; j < WORD_COUNT; j++)
            keep[j] = (32'(len_r) < MAX_WORD_LEN) && (word_at(j, len_r) == c);
          cand_nxt = cand_r & keep;
          if (len_r != 4'd15) len_nxt = len_r + 4'd1;
        end else begin
          t = '0; t.vld = 1'b1; t.kind = KIND_IDENT;
          for (int j = WORD_COUNT-1; j >= 0; j--)
            if (cand_r[j] && word_len(j) == len_r) begin
              t.kind = (j < TYPE_COUNT) ? KIND_TYPE : KIND_KEYWORD;
              t.idx  = (j < TYPE_COUNT) ? 4'(j) : 4'(j - TYPE_COUNT);
            end
          t.s = clip(ts_r); t.e = clip(prev); t.line = clip(tl_r);
          r[n] = t; n++;
          mode_nxt = M_IDLE;
        end
      end
      M_NUMBER: begin
        if (is_digit(c)) used = 1'b1;
        else begin
          t = '0; t.vld = 1'b1; t.kind = KIND_NUMBER;
          t.s = clip(ts_r); t.e = clip(prev); t.line = clip(tl_r);
          r[n] = t; n++;
          mode_nxt = M_IDLE;
        end
      end
      M_SLASH: begin
        if (c == "/") begin
          mode_nxt = M_LINE; used = 1'b1;
        end else if (c == "*") begin
          mode_nxt = M_BLOCK; star_nxt = 1'b0; used = 1'b1;
        end else begin
          t = '0; t.vld = 1'b1; t.kind = KIND_SYMBOL; t.ch = "/";
          t.s = clip(ts_r); t.e = clip(ts_r); t.line = clip(tl_r);
          r[n] = t; n++;
          mode_nxt = M_IDLE;
        end
      end
      M_LINE: begin
        used = 1'b1;
        if (c == 8'h0A) begin
          t = '0; t.vld = 1'b1; t.kind = KIND_LINECMT;
          t.s = clip(ts_r); t.e = clip(cur); t.line = clip(tl_r);
          r[n] = t; n++;
          mode_nxt = M_IDLE;
          if (lc_r != CMAX) lc_nxt = lc_r + 1'b1;
        end
      end
      M_BLOCK: begin
        used = 1'b1;
        if (c == "/" && star_r) begin
          t = '0; t.vld = 1'b1; t.kind = KIND_BLKCMT;
          t.s = clip(ts_r); t.e = clip(cur); t.line = clip(tl_r);
          r[n] = t; n++;
          mode_nxt = M_IDLE; star_nxt = 1'b0;
        end else begin
          star_nxt = (c == "*");
          if (c == 8'h0A && lc_r != CMAX) lc_nxt = lc_r + 1'b1;
        end
      end
      M_STRING: begin
        used = 1'b1;
        if (c == 8'h22) begin
          t = '0; t.vld = 1'b1; t.kind = KIND_STRING;
          t.s = clip(ts_r); t.e = clip(cur); t.line = clip(tl_r);
          r[n] = t; n++;
          mode_nxt = M_IDLE;
        end else if (c == 8'h0A && lc_r != CMAX) lc_nxt = lc_r + 1'b1;
      end
      default: mode_nxt = M_IDLE;
    endcase

    if (!used) begin
      ts_nxt = cur;
      tl_nxt = lc_r;
      if (c == " " || c == 8'h09 || c == 8'h0A) begin
        if (c == 8'h0A && lc_r != CMAX) lc_nxt = lc_r + 1'b1;
      end else if (is_letter(c)) begin
        mode_nxt = M_IDENT;
        for (int j = 0; j < WORD_COUNT; j++) keep[j] = (word_at(j, 4'd0) == c);
        cand_nxt = keep;
        len_nxt = 4'd1;
      end else if (is_digit(c)) mode_nxt = M_NUMBER;
      else if (c == "/") mode_nxt = M_SLASH;
      else if (c == 8'h22) mode_nxt = M_STRING;
      else begin
        t = '0; t.vld = 1'b1; t.kind = is_symbol(c) ? KIND_SYMBOL : KIND_BAD; t.ch = c;
        t.s = clip(cur); t.e = clip(cur); t.line = clip(lc_r);
        r[n] = t; n++;
      end
    end

    if (last) begin
      t = '0; t.vld = 1'b1; t.s = clip(ts_nxt); t.e = clip(cur); t.line = clip(tl_nxt);
      case (mode_nxt)
        M_IDENT: begin
          t.kind = KIND_IDENT;
          for (int j = WORD_COUNT-1; j >= 0; j--)
            if (cand_nxt[j] && word_len(j) == len_nxt) begin
              t.kind = (j < TYPE_COUNT) ? KIND_TYPE : KIND_KEYWORD;
              t.idx  = (j < TYPE_COUNT) ? 4'(j) : 4'(j - TYPE_COUNT);
            end
        end
        M_NUMBER: t.kind = KIND_NUMBER;
        M_SLASH: begin
          t.kind = KIND_SYMBOL; t.ch = "/"; t.e = clip(ts_nxt);
        end
        M_LINE:  t.kind = KIND_LINECMT;
        M_BLOCK, M_STRING: t.kind = KIND_UNTERM;
        default: t.vld = 1'b0;
      endcase
      if (t.vld && n < 2) begin
        r[n] = t; n++;
      end
      mode_nxt = M_IDLE; off_nxt = '0; lc_nxt = OFFSET_BITS'(1); ts_nxt = '0;
      tl_nxt = OFFSET_BITS'(1); cand_nxt = '0; len_nxt = '0; star_nxt = 1'b0;
    end else if (off_r != CMAX) off_nxt = off_r + 1'b1;

    tok0 = r[0];
    tok1 = r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; off_r <= '0; lc_r <= OFFSET_BITS'(1); ts_r <= '0;
      tl_r <= OFFSET_BITS'(1); cand_r <= '0; len_r <= '0; star_r <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt; off_r <= off_nxt; lc_r <= lc_nxt; ts_r <= ts_nxt;
      tl_r <= tl_nxt; cand_r <= cand_nxt; len_r <= len_nxt; star_r <= star_nxt;
    end
  end
endmodule

>>> hdl/sts_outq.sv
// ----------------------------------------------------------------------------
// sts_outq
// Two-token result buffer; drains one token per beat, flags the last of a byte.
// ----------------------------------------------------------------------------
module sts_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  sts_pkg::tok_t tok0,
  input  sts_pkg::tok_t tok1,
  input  logic          out_ready,
  output logic          out_valid,
  output sts_pkg::tok_t head,
  output logic          head_last,
  output logic          can_load
);
  import sts_pkg::*;

  tok_t q0_r, q1_r;
  logic v0_r, v1_r;
  logic pop;

  assign out_valid = v0_r;
  assign head      = q0_r;
  assign head_last = !v1_r;
  assign pop       = v0_r && out_ready;
  assign can_load  = !v0_r || (pop && !v1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0;
    end else if (load) begin
      v0_r <= tok0.vld; v1_r <= tok1.vld;
    end else if (pop) begin
      v0_r <= v1_r; v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0_r <= tok0; q1_r <= tok1;
    end else if (pop) begin
      q0_r <= q1_r;
    end
  end
endmodule

>>> hdl/source_token_scanner_top.sv
// Output: the first token that a byte closes is registered and shown in the cycle after that byte is taken.
// Throughput: one byte per cycle while out_ready is high; a byte that closes two tokens holds
// input until the second token drains.
// Reset: rst_n synchronous, active low; idle mode, offset 0, line 1.
// ----------------------------------------------------------------------------
// source_token_scanner_top
// Byte-stream tokenizer: scan core plus two-entry result buffer.
// ----------------------------------------------------------------------------
module source_token_scanner_top #(
  parameter int OFFSET_BITS  = 16,
  parameter int MAX_WORD_LEN = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [3:0]  out_word_index,
  output logic [7:0]  out_symbol_char,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_end_offset,
  output logic [15:0] out_line_number,
  output logic        out_last_of_run
);
  import sts_pkg::*;

  tok_t tok0, tok1, head;
  logic adv, can_load, head_last;

  assign in_ready = can_load;
  assign adv      = in_valid && can_load;

  sts_core #(.OFFSET_BITS(OFFSET_BITS), .MAX_WORD_LEN(MAX_WORD_LEN)) u_core (
    .clk(clk), .rst_n(rst_n), .adv(adv), .c(in_char_byte), .last(in_end_of_input),
    .tok0(tok0), .tok1(tok1)
  );

  sts_outq u_outq (
    .clk(clk), .rst_n(rst_n), .load(adv), .tok0(tok0), .tok1(tok1),
    .out_ready(out_ready), .out_valid(out_valid), .head(head),
    .head_last(head_last), .can_load(can_load)
  );

  assign out_token_kind   = head.kind;
  assign out_word_index   = head.idx;
  assign out_symbol_char  = head.ch;
  assign out_start_offset = head.s;
  assign out_end_offset   = head.e;
  assign out_line_number  = head.line;
  assign out_last_of_run  = head_last;
endmodule
